// ===== rtl/rtr_pkg.sv =====
// Shared types and constants for the rigid transform ray unit.
`timescale 1ns / 1ps

package rtr_pkg;

    localparam int CFG_INDEX_WIDTH = 3;

    // Configuration register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MATRIX_ROW0 = 3'd0,
        REG_MATRIX_ROW1 = 3'd1,
        REG_MATRIX_ROW2 = 3'd2,
        REG_SHIFT_X     = 3'd3,
        REG_SHIFT_Y     = 3'd4,
        REG_SHIFT_Z     = 3'd5
    } t_cfg_reg;

endpackage

// ===== rtl/rtr_cfg_regs.sv =====
// Rotation matrix and translation registers with their write port.
`timescale 1ns / 1ps

module rtr_cfg_regs
    import rtr_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEFF_WIDTH = 18,
    parameter int DATA_WIDTH  = 54
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]   i_wr_index,
    input  logic [DATA_WIDTH-1:0]        i_wr_data,
    output logic [3*COEFF_WIDTH-1:0]     o_row [3],
    output logic [COORD_WIDTH-1:0]       o_shift [3]
);

    localparam int ROW_WIDTH = 3 * COEFF_WIDTH;
    localparam int FRAC_C    = COEFF_WIDTH - 2;

    logic [ROW_WIDTH-1:0]   r_row [3];
    logic [COORD_WIDTH-1:0] r_shift [3];

    // Reset loads the identity matrix and a zero translation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= ROW_WIDTH'(1) << FRAC_C;
            r_row[1]   <= ROW_WIDTH'(1) << (FRAC_C + COEFF_WIDTH);
            r_row[2]   <= ROW_WIDTH'(1) << (FRAC_C + 2 * COEFF_WIDTH);
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_wr_en) begin
            case (t_cfg_reg'(i_wr_index))
                REG_MATRIX_ROW0: r_row[0]   <= i_wr_data[ROW_WIDTH-1:0];
                REG_MATRIX_ROW1: r_row[1]   <= i_wr_data[ROW_WIDTH-1:0];
                REG_MATRIX_ROW2: r_row[2]   <= i_wr_data[ROW_WIDTH-1:0];
                REG_SHIFT_X:     r_shift[0] <= i_wr_data[COORD_WIDTH-1:0];
                REG_SHIFT_Y:     r_shift[1] <= i_wr_data[COORD_WIDTH-1:0];
                REG_SHIFT_Z:     r_shift[2] <= i_wr_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_row   = r_row;
    assign o_shift = r_shift;

endmodule

// ===== rtl/rtr_dot3.sv =====
// Three-term dot product lane: operand, product and rounded-sum registers.
`timescale 1ns / 1ps

module rtr_dot3 #(
    parameter int OP_WIDTH = 33,
    parameter int CF_WIDTH = 18,
    parameter int FRAC     = 16,
    localparam int PROD_WIDTH = OP_WIDTH + CF_WIDTH,
    localparam int SUM_WIDTH  = PROD_WIDTH + 2,
    localparam int RND_WIDTH  = SUM_WIDTH - FRAC
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [OP_WIDTH-1:0]  i_op [3],
    input  logic signed [CF_WIDTH-1:0]  i_cf [3],
    output logic signed [RND_WIDTH-1:0] o_rnd
);

    localparam logic [SUM_WIDTH-1:0] ROUND_BIAS =
        {{(SUM_WIDTH-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

    logic signed [OP_WIDTH-1:0]   r_op [3];
    logic signed [CF_WIDTH-1:0]   r_cf [3];
    logic signed [PROD_WIDTH-1:0] r_prod [3];
    logic signed [PROD_WIDTH-1:0] n_prod [3];
    logic signed [SUM_WIDTH-1:0]  n_sum;
    logic signed [RND_WIDTH-1:0]  r_rnd;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = PROD_WIDTH'(r_op[k]) * PROD_WIDTH'(r_cf[k]);
        end
        // ties round toward plus infinity: add half an LSB, then floor
        n_sum = SUM_WIDTH'(r_prod[0]) + SUM_WIDTH'(r_prod[1])
              + SUM_WIDTH'(r_prod[2]) + $signed(ROUND_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op   <= i_op;
            r_cf   <= i_cf;
            r_prod <= n_prod;
            r_rnd  <= n_sum[SUM_WIDTH-1:FRAC];
        end
    end

    assign o_rnd = r_rnd;

endmodule

// ===== rtl/rigid_transform_ray_unit.sv =====
// Top level of the rigid transform ray unit.
//
// Rays enter on the s_axis channel (origin and direction, Q16.16, plus
// the inverse flag in tuser) and leave on the m_axis channel (rotated
// origin and direction, overflow flag in tuser). The matrix rows and the
// translation are written on the cfg channel, which is always ready; write
// them only while no ray is in flight.
// Path: the result reaches m_axis through the input register, operand
// register, product register, rounded sum register and saturated output
// register. Throughput: one ray per cycle unless the receiver stalls;
// six three-term dot product lanes work in parallel, each stage holding
// a different ray.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and s_axis_tready drops; a free output register keeps it moving.
// Reset clears all valid flags and loads the identity matrix and a zero
// translation.
`timescale 1ns / 1ps

module rigid_transform_ray_unit
    import rtr_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEFF_WIDTH = 18,
    localparam int DATA_WIDTH = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int CFG_WIDTH  = (3 * COEFF_WIDTH > COORD_WIDTH) ?
                                3 * COEFF_WIDTH : COORD_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Ray input
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // org_x, org_y, org_z, dir_x, dir_y, dir_z from bit 0 up
    input  logic [DATA_WIDTH-1:0]      s_axis_tdata,
    // backward
    input  logic                       s_axis_tuser,
    // Result output
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // new_org_x, new_org_y, new_org_z, new_dir_x, new_dir_y, new_dir_z from bit 0 up
    output logic [DATA_WIDTH-1:0]      m_axis_tdata,
    // overflow
    output logic                       m_axis_tuser,
    // Configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]       i_cfg_data
);

    localparam int FRAC_C    = COEFF_WIDTH - 2;
    localparam int OP_WIDTH  = COORD_WIDTH + 1;
    localparam int RND_WIDTH = OP_WIDTH + COEFF_WIDTH + 2 - FRAC_C;
    localparam int FIN_WIDTH = RND_WIDTH + 1;
    localparam int PAD_WIDTH = DATA_WIDTH - 6 * COORD_WIDTH;

    logic [3*COEFF_WIDTH-1:0] row [3];
    logic [COORD_WIDTH-1:0]   shift [3];

    logic                     en;
    logic [3:0]               r_vld;
    logic [3:0]               r_bwd;
    logic [COORD_WIDTH-1:0]   r_a_coord [6];

    logic signed [OP_WIDTH-1:0]    op [6];
    logic signed [COEFF_WIDTH-1:0] cf [3][3];
    logic signed [RND_WIDTH-1:0]   rnd [6];

    logic                   r_out_valid;
    logic [COORD_WIDTH-1:0] r_out_coord [6];
    logic                   r_out_ovf;
    logic [COORD_WIDTH-1:0] n_out_coord [6];
    logic                   n_out_ovf;

    assign o_cfg_ready = 1'b1;

    rtr_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEFF_WIDTH (COEFF_WIDTH),
        .DATA_WIDTH  (CFG_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_row      (row),
        .o_shift    (shift)
    );

    // One enable for the whole pipeline: advance unless a result is stuck
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[2:0], s_axis_tvalid};
            r_out_valid <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bwd <= {r_bwd[2:0], s_axis_tuser};
            for (int k = 0; k < 6; k++) begin
                r_a_coord[k] <= s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    // Operand and coefficient selection; inverse subtracts the translation
    // exactly (one extra bit) and uses the transposed matrix.
    always_comb begin
        logic signed [OP_WIDTH-1:0] org_e;
        logic signed [OP_WIDTH-1:0] sh_e;
        for (int i = 0; i < 3; i++) begin
            org_e     = $signed({r_a_coord[i][COORD_WIDTH-1], r_a_coord[i]});
            sh_e      = $signed({shift[i][COORD_WIDTH-1], shift[i]});
            op[i]     = r_bwd[0] ? org_e - sh_e : org_e;
            op[i + 3] = $signed({r_a_coord[i + 3][COORD_WIDTH-1], r_a_coord[i + 3]});
            for (int j = 0; j < 3; j++) begin
                cf[i][j] = r_bwd[0] ? $signed(row[j][i*COEFF_WIDTH +: COEFF_WIDTH])
                                    : $signed(row[i][j*COEFF_WIDTH +: COEFF_WIDTH]);
            end
        end
    end

    // Lanes 0..2 rotate the origin, lanes 3..5 the direction
    for (genvar g = 0; g < 6; g++) begin : g_lane
        logic signed [OP_WIDTH-1:0] lane_op [3];
        assign lane_op[0] = (g < 3) ? op[0] : op[3];
        assign lane_op[1] = (g < 3) ? op[1] : op[4];
        assign lane_op[2] = (g < 3) ? op[2] : op[5];

        rtr_dot3 #(
            .OP_WIDTH (OP_WIDTH),
            .CF_WIDTH (COEFF_WIDTH),
            .FRAC     (FRAC_C)
        ) u_dot (
            .i_clk (i_clk),
            .i_en  (en),
            .i_op  (lane_op),
            .i_cf  (cf[g % 3]),
            .o_rnd (rnd[g])
        );
    end

    // Forward adds the translation to the rounded origin, then all six saturate
    always_comb begin
        logic signed [FIN_WIDTH-1:0] fin;
        logic signed [FIN_WIDTH-1:0] tr_e;
        logic                        fits;
        n_out_ovf = 1'b0;
        for (int k = 0; k < 6; k++) begin
            tr_e = (k < 3 && !r_bwd[3]) ?
                   FIN_WIDTH'($signed(shift[k % 3])) : '0;
            fin  = FIN_WIDTH'(rnd[k]) + tr_e;
            fits = (&fin[FIN_WIDTH-1:COORD_WIDTH-1]) || !(|fin[FIN_WIDTH-1:COORD_WIDTH-1]);
            if (fits) begin
                n_out_coord[k] = fin[COORD_WIDTH-1:0];
            end else begin
                n_out_coord[k] = fin[FIN_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                                  : {1'b0, {(COORD_WIDTH-1){1'b1}}};
                n_out_ovf      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_coord <= n_out_coord;
            r_out_ovf   <= n_out_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ovf;

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < 6; k++) begin
            m_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH] = r_out_coord[k];
        end
        if (PAD_WIDTH > 0) begin
            m_axis_tdata[DATA_WIDTH-1 -: ((PAD_WIDTH > 0) ? PAD_WIDTH : 1)] = '0;
        end
    end

endmodule

// ===== test/rigid_transform_ray_unit_test.sv =====
// Self-checking testbench for the rigid transform ray unit.
`timescale 1ns / 1ps

module rigid_transform_ray_unit_test;
    import rtr_pkg::*;

    localparam int COORD_W  = 32;
    localparam int COEFF_W  = 18;
    localparam int FRAC_C   = COEFF_W - 2;
    localparam int ROW_W    = 3 * COEFF_W;
    localparam int DATA_W   = ((6 * COORD_W + 7) / 8) * 8;
    localparam int CFG_W    = (ROW_W > COORD_W) ? ROW_W : COORD_W;
    localparam int JUNK_W   = CFG_W - COORD_W;

    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_MAX      = 10;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 80;

    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_INVERSE = 1'b1;

    // indexes past the register map, writes there must change nothing
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LO = CFG_INDEX_WIDTH'(REG_SHIFT_Z + 1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_HI = CFG_INDEX_WIDTH'(REG_SHIFT_Z + 2);

    localparam logic [COORD_W-1:0] CMAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] CMIN = 32'h8000_0000;
    localparam logic [COEFF_W-1:0] KMAX = 18'h1FFFF;
    localparam logic [COEFF_W-1:0] KMIN = 18'h20000;
    localparam logic [COEFF_W-1:0] KONE = 18'h10000;
    localparam logic [COEFF_W-1:0] KLSB = 18'h00001;
    localparam logic [COEFF_W-1:0] KZERO = 18'h00000;

    typedef struct packed {
        logic                      backward;
        logic [5:0][COORD_W-1:0]   v;  // org_x, org_y, org_z, dir_x, dir_y, dir_z from v[0]
    } t_ray;

    typedef struct packed {
        logic                      ovf;
        logic [5:0][COORD_W-1:0]   v;
    } t_result;

    class ray_scoreboard;
        logic [ROW_W-1:0]   rows [3];
        logic [COORD_W-1:0] shifts [3];
        t_result            pending_q [$];
        int                 failures;
        string              field_names [6] = '{"new_org_x", "new_org_y", "new_org_z",
                                                "new_dir_x", "new_dir_y", "new_dir_z"};

        function new();
            rows[0]   = ROW_W'(KONE);
            rows[1]   = ROW_W'(KONE) << COEFF_W;
            rows[2]   = ROW_W'(KONE) << (2 * COEFF_W);
            shifts[0] = '0;
            shifts[1] = '0;
            shifts[2] = '0;
            failures  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_MATRIX_ROW0, REG_MATRIX_ROW1, REG_MATRIX_ROW2:
                    rows[idx[1:0]] = data[ROW_W-1:0];
                REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z:
                    shifts[int'(idx) - int'(REG_SHIFT_X)] = data[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        function longint coeff(int r, int c);
            return longint'($signed(rows[r][c*COEFF_W +: COEFF_W]));
        endfunction

        // exact three-term sum, one rounding, ties toward +inf
        function longint round_dot(longint c0, longint c1, longint c2,
                                   longint a0, longint a1, longint a2);
            longint acc;
            acc = c0 * a0 + c1 * a1 + c2 * a2 + (longint'(1) <<< (FRAC_C - 1));
            return acc >>> FRAC_C;
        endfunction

        function logic [COORD_W-1:0] clamp(longint x, inout bit ovf);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (COORD_W - 1)) - 1;
            lo = -hi - 1;
            if (x > hi) begin
                x = hi;
                ovf = 1'b1;
            end else if (x < lo) begin
                x = lo;
                ovf = 1'b1;
            end
            return x[COORD_W-1:0];
        endfunction

        function void note_ray(t_ray r);
            longint  o [3];
            longint  d [3];
            longint  t [3];
            longint  ro;
            longint  rd;
            t_result want;
            bit      ovf;
            int      i;
            ovf = 1'b0;
            for (i = 0; i < 3; i++) begin
                o[i] = longint'($signed(r.v[i]));
                d[i] = longint'($signed(r.v[i+3]));
                t[i] = longint'($signed(shifts[i]));
            end
            for (i = 0; i < 3; i++) begin
                if (r.backward == DIR_INVERSE) begin
                    // translation comes off first, kept one bit wider
                    ro = round_dot(coeff(0, i), coeff(1, i), coeff(2, i),
                                   o[0] - t[0], o[1] - t[1], o[2] - t[2]);
                    rd = round_dot(coeff(0, i), coeff(1, i), coeff(2, i), d[0], d[1], d[2]);
                end else begin
                    ro = round_dot(coeff(i, 0), coeff(i, 1), coeff(i, 2), o[0], o[1], o[2])
                         + t[i];
                    rd = round_dot(coeff(i, 0), coeff(i, 1), coeff(i, 2), d[0], d[1], d[2]);
                end
                want.v[i]   = clamp(ro, ovf);
                want.v[i+3] = clamp(rd, ovf);
            end
            want.ovf = ovf;
            pending_q.push_back(want);
        endfunction

        function void check_result(t_result got);
            t_result want;
            int      k;
            if (pending_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result transfer: %h", got);
                return;
            end
            want = pending_q.pop_front();
            for (k = 0; k < 6; k++) begin
                if (got.v[k] !== want.v[k]) begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("%s: expected %h, got %h", field_names[k], want.v[k], got.v[k]);
                end
            end
            if (got.ovf !== want.ovf) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("overflow: expected %b, got %b", want.ovf, got.ovf);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [DATA_W-1:0]          s_axis_tdata;
    logic                       s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [DATA_W-1:0]          m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;

    ray_scoreboard sb = new();
    bit            tx_idle_on = 1'b1;
    bit            rx_calm = 1'b0;
    bit            hold_req = 1'b0;
    int            hold_cnt;
    int            quiet_cycles = 0;

    rigid_transform_ray_unit #(
        .COORD_WIDTH(COORD_W),
        .COEFF_WIDTH(COEFF_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            m_axis_tready <= 1'b0;
            for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge i_clk);
            hold_req = 1'b0;
        end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_result'({m_axis_tuser, m_axis_tdata}));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rigid_transform_ray_unit_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_ray mk_ray(logic [COORD_W-1:0] ox, oy, oz, dx, dy, dz, logic bw);
        return t_ray'({bw, dz, dy, dx, oz, oy, ox});
    endfunction

    function automatic t_ray fill_ray(logic [COORD_W-1:0] c, logic bw);
        return mk_ray(c, c, c, c, c, c, bw);
    endfunction

    function automatic logic [CFG_W-1:0] pack_row(logic [COEFF_W-1:0] c0, c1, c2);
        return CFG_W'({c2, c1, c0});
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return CMAX;
            1:       return CMIN;
            2, 3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] rand_coeff();
        logic [31:0] u;
        case ($urandom_range(0, 7))
            0:       u = 32'(KMAX);
            1:       u = 32'(KMIN);
            2:       u = '0;
            3, 4, 5: u = $urandom_range(0, 2 * KONE) - KONE;  // within +-1.0
            default: u = $urandom();
        endcase
        return u[COEFF_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] rand_row();
        if ($urandom_range(0, 3) == 0)
            return CFG_W'({$urandom(), $urandom()});
        return pack_row(rand_coeff(), rand_coeff(), rand_coeff());
    endfunction

    // upper bits are junk, the block must drop them
    function automatic logic [CFG_W-1:0] rand_shift();
        return {JUNK_W'($urandom()), rand_coord()};
    endfunction

    function automatic t_ray rand_ray();
        return mk_ray(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
    endfunction

    // leaves tvalid high, the caller drops it after the last transfer
    task automatic send_ray(t_ray r);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 18);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.v;
        s_axis_tuser  <= r.backward;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_ray(r);
    endtask

    task automatic finish_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic load_setting(logic [CFG_W-1:0] m0, m1, m2, sx, sy, sz);
        cfg_write(REG_MATRIX_ROW0, m0);
        cfg_write(REG_MATRIX_ROW1, m1);
        cfg_write(REG_MATRIX_ROW2, m2);
        cfg_write(REG_SHIFT_X, sx);
        cfg_write(REG_SHIFT_Y, sy);
        cfg_write(REG_SHIFT_Z, sz);
        cfg_write($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                  CFG_W'({$urandom(), $urandom()}));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_MATRIX_ROW0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset matrix is identity with no translation
        send_ray(fill_ray('0, DIR_FORWARD));
        send_ray(mk_ray(CMAX, CMIN, 32'h1, 32'hFFFF_FFFF, CMIN, CMAX, DIR_FORWARD));
        send_ray(mk_ray(CMAX, CMIN, 32'h1, 32'hFFFF_FFFF, CMIN, CMAX, DIR_INVERSE));
        finish_burst();

        // one-LSB coefficients put half-LSB ties on the rounding
        load_setting(pack_row(KLSB, KZERO, KZERO), pack_row(KZERO, KLSB, KZERO),
                     pack_row(KLSB, KLSB, KLSB),
                     CFG_W'(32'h0001_0000), CFG_W'(32'hFFFF_0000), '0);
        send_ray(mk_ray(32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF,
                        32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_7FFF, DIR_FORWARD));
        send_ray(mk_ray(32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF,
                        32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_7FFF, DIR_INVERSE));
        send_ray(mk_ray(32'hFFFF_7FFF, 32'h0000_8001, 32'h0000_8000,
                        32'hFFFF_8001, 32'h0000_7FFF, 32'h0001_8000, DIR_FORWARD));
        send_ray(mk_ray(32'hFFFF_7FFF, 32'h0000_8001, 32'h0000_8000,
                        32'hFFFF_8001, 32'h0000_7FFF, 32'h0001_8000, DIR_INVERSE));
        finish_burst();

        // largest coefficients, extreme translation with junk above bit 31
        load_setting(pack_row(KMAX, KMAX, KMAX), pack_row(KMAX, KMAX, KMAX),
                     pack_row(KMAX, KMAX, KMAX), {{JUNK_W{1'b1}}, CMAX},
                     CFG_W'(CMAX), CFG_W'(CMIN));
        send_ray(fill_ray(CMAX, DIR_FORWARD));
        send_ray(fill_ray(CMAX, DIR_INVERSE));
        send_ray(fill_ray(CMIN, DIR_FORWARD));
        send_ray(fill_ray(CMIN, DIR_INVERSE));
        send_ray(mk_ray(CMIN, CMIN, CMAX, '0, '0, '0, DIR_INVERSE));
        finish_burst();

        // rotated origin overshoots, translation pulls it back in range
        load_setting(pack_row(KMAX, KZERO, KZERO), pack_row(KZERO, KMAX, KZERO),
                     pack_row(KZERO, KZERO, KMAX),
                     CFG_W'(CMIN), CFG_W'(CMIN), CFG_W'(CMIN));
        send_ray(mk_ray(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, '0, '0, '0, DIR_FORWARD));
        send_ray(mk_ray(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, '0, '0, '0, DIR_INVERSE));
        send_ray(mk_ray('0, '0, '0, CMAX, CMIN, CMAX, DIR_FORWARD));
        send_ray(mk_ray(CMIN, CMAX, CMIN, CMIN, CMAX, '0, DIR_INVERSE));
        finish_burst();

        load_setting(pack_row(KMIN, KMIN, KMIN), pack_row(KMIN, KMIN, KMIN),
                     pack_row(KMIN, KMIN, KMIN), '0, '0, '0);
        send_ray(fill_ray(CMAX, DIR_FORWARD));
        send_ray(fill_ray(CMAX, DIR_INVERSE));
        send_ray(fill_ray(CMIN, DIR_FORWARD));
        send_ray(fill_ray(CMIN, DIR_INVERSE));
        finish_burst();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_setting(rand_row(), rand_row(), rand_row(),
                         rand_shift(), rand_shift(), rand_shift());
            if (ph == 0)
                hold_req = 1'b1;
            if (ph == RANDOM_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_calm    = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_ray(rand_ray());
            finish_burst();
        end

        if (sb.failures == 0)
            $display("rigid_transform_ray_unit_test OK");
        else
            $display("rigid_transform_ray_unit_test NOT OK");
        $finish;
    end

endmodule
